[rtl/ttlc_pkg.sv]
package ttlc_pkg;

    // Phase codes of the controller state.
    localparam logic [2:0] PH_INIT  = 3'd0;
    localparam logic [2:0] PH_ONE   = 3'd1;
    localparam logic [2:0] PH_TWO   = 3'd2;
    localparam logic [2:0] PH_THREE = 3'd3;
    localparam logic [2:0] PH_FOUR  = 3'd4;
    localparam logic [2:0] PH_MAN   = 3'd5;

    // Lamp vector bit masks.
    localparam logic [5:0] LAMP_RA = 6'b000001;
    localparam logic [5:0] LAMP_YA = 6'b000010;
    localparam logic [5:0] LAMP_GA = 6'b000100;
    localparam logic [5:0] LAMP_RB = 6'b001000;
    localparam logic [5:0] LAMP_YB = 6'b010000;
    localparam logic [5:0] LAMP_GB = 6'b100000;
    localparam logic [5:0] LAMP_A  = LAMP_RA | LAMP_YA | LAMP_GA;
    localparam logic [5:0] LAMP_B  = LAMP_RB | LAMP_YB | LAMP_GB;

    // Register word indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_GREEN  = 2'd0;
    localparam logic [1:0] REG_YELLOW = 2'd1;
    localparam logic [1:0] REG_WAIT   = 2'd2;
    localparam logic [1:0] REG_TICK   = 2'd3;

    // Reset values.
    localparam logic [7:0] GREEN_RST   = 8'd3;
    localparam logic [7:0] YELLOW_RST  = 8'd2;
    localparam logic [7:0] WAIT_RST    = 8'd10;
    localparam logic [4:0] TICK_RST    = 5'd20;
    localparam logic [7:0] DISPLAY_RST = 8'd5;
    localparam logic [4:0] SUB_RST     = 5'd20;

    // Sub-second counter step: returns {second_boundary, next_counter}.
    function automatic logic [5:0] sec_step(input logic [4:0] sub, input logic [4:0] reload);
        logic [4:0] base;
        logic       fire;
        base = sub;
        fire = 1'b0;
        if (sub == 5'd0)
        begin
            base = reload;
            fire = 1'b1;
        end
        return {fire, base - 5'd1};
    endfunction

endpackage

[rtl/two_way_traffic_light_controller.sv]
// Two-way traffic light controller. Each word on the tick channel is one
// 50 ms tick carrying the manual request button; each tick yields exactly one
// result word with the six lamp states, the value shown on the countdown
// display and a flag that is high during the manual blinking hold. A tick is
// held in an input register and stepped through the controller into the
// result register, so the block takes one word per clock cycle while the
// result channel does not stall. While a finished result waits for the
// downstream side, the input register can still take one more tick; after
// that the tick channel stalls until the result word is taken. Phase
// lengths for green and yellow, the length of the manual hold and the
// number of ticks per second are set over the APB port at byte addresses
// 0, 4, 8 and 12, and are to be written only while the block is idle.
module two_way_traffic_light_controller
    import ttlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Tick channel.
    input  logic        tick_valid,
    output logic        tick_stall,
    input  logic        manual_button,

    // Result channel.
    output logic        result_valid,
    input  logic        result_stall,
    output logic        red_a,
    output logic        yellow_a,
    output logic        green_a,
    output logic        red_b,
    output logic        yellow_b,
    output logic        green_b,
    output logic [7:0]  shown_count,
    output logic        in_manual,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0] green_reg;
    logic [7:0] yellow_reg;
    logic [7:0] wait_reg;
    logic [4:0] tick_reg;

    // Input stage.
    logic       s1_valid_reg;
    logic       s1_button_reg;

    // Controller state. The lamp and display registers double as the
    // result payload, since each tick rewrites them for its own result.
    logic       result_valid_reg;
    logic [2:0] phase_reg,        phase_next;
    logic [7:0] phase_left_reg,   phase_left_next;
    logic [7:0] display_left_reg, display_left_next;
    logic [4:0] sub_second_reg,   sub_second_next;
    logic [7:0] hold_left_reg,    hold_left_next;
    logic [5:0] lamps_reg,        lamps_next;
    logic [7:0] shown_reg,        shown_next;

    logic [5:0] sec_phase;
    logic [5:0] sec_manual;
    logic       advance;
    logic       step;
    logic       cfg_write;

    // The result register can take a new word when it is empty or is being
    // drained this cycle; a full input register holds while it cannot.
    assign advance    = !result_valid_reg || !result_stall;
    assign step       = s1_valid_reg && advance;
    assign tick_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!tick_stall)
        begin
            s1_valid_reg <= tick_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
        begin
            s1_button_reg <= manual_button;
        end
    end

    // One controller step. The phase logic runs first; the manual hold logic
    // runs after it within the same tick, so the tick that enters the hold
    // also runs one hold step and advances the sub-second counter twice.
    always_comb
    begin
        phase_next        = phase_reg;
        phase_left_next   = phase_left_reg;
        display_left_next = display_left_reg;
        sub_second_next   = sub_second_reg;
        hold_left_next    = hold_left_reg;
        lamps_next        = lamps_reg;
        shown_next        = shown_reg;

        sec_phase = sec_step(sub_second_reg, tick_reg);

        case (phase_reg)
            PH_INIT:
            begin
                phase_left_next   = green_reg;
                display_left_next = 8'(green_reg + yellow_reg);
                lamps_next        = LAMP_RA | LAMP_GB;
                shown_next        = 8'(green_reg + yellow_reg);
                phase_next        = PH_ONE;
            end
            PH_ONE, PH_TWO, PH_THREE, PH_FOUR:
            begin
                shown_next      = display_left_reg;
                sub_second_next = sec_phase[4:0];
                if (sec_phase[5])
                begin
                    display_left_next = display_left_reg - 8'd1;
                    phase_left_next   = phase_left_reg - 8'd1;
                end
                if (phase_left_next == 8'd0)
                begin
                    case (phase_reg)
                        PH_ONE:
                        begin
                            lamps_next      = (lamps_reg & LAMP_A) | LAMP_YB;
                            phase_left_next = yellow_reg;
                            phase_next      = PH_TWO;
                        end
                        PH_TWO:
                        begin
                            phase_left_next   = green_reg;
                            lamps_next        = LAMP_GA | LAMP_RB;
                            display_left_next = green_reg;
                            phase_next        = PH_THREE;
                        end
                        PH_THREE:
                        begin
                            phase_left_next   = yellow_reg;
                            lamps_next        = (lamps_reg & LAMP_B) | LAMP_YA;
                            display_left_next = yellow_reg;
                            phase_next        = PH_FOUR;
                        end
                        default:
                        begin
                            phase_left_next   = green_reg;
                            lamps_next        = LAMP_RA | LAMP_GB;
                            display_left_next = 8'(green_reg + yellow_reg);
                            phase_next        = PH_ONE;
                        end
                    endcase
                end
                // A button press in the first phase overrides the phase end.
                if ((phase_reg == PH_ONE) && s1_button_reg)
                begin
                    lamps_next     = LAMP_RA | LAMP_RB;
                    hold_left_next = wait_reg;
                    phase_next     = PH_MAN;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        sec_manual = sec_step(sub_second_next, tick_reg);

        if (phase_next == PH_MAN)
        begin
            shown_next      = hold_left_next;
            sub_second_next = sec_manual[4:0];
            if (sec_manual[5])
            begin
                lamps_next     = lamps_next ^ (LAMP_RA | LAMP_RB);
                hold_left_next = hold_left_next - 8'd1;
            end
            if (hold_left_next == 8'd0)
            begin
                phase_next = PH_INIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            phase_reg        <= PH_INIT;
            phase_left_reg   <= 8'd0;
            display_left_reg <= DISPLAY_RST;
            sub_second_reg   <= SUB_RST;
            hold_left_reg    <= 8'd0;
            lamps_reg        <= 6'd0;
            shown_reg        <= 8'd0;
        end
        else
        begin
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
            if (step)
            begin
                phase_reg        <= phase_next;
                phase_left_reg   <= phase_left_next;
                display_left_reg <= display_left_next;
                sub_second_reg   <= sub_second_next;
                hold_left_reg    <= hold_left_next;
                lamps_reg        <= lamps_next;
                shown_reg        <= shown_next;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign red_a        = |(lamps_reg & LAMP_RA);
    assign yellow_a     = |(lamps_reg & LAMP_YA);
    assign green_a      = |(lamps_reg & LAMP_GA);
    assign red_b        = |(lamps_reg & LAMP_RB);
    assign yellow_b     = |(lamps_reg & LAMP_YB);
    assign green_b      = |(lamps_reg & LAMP_GB);
    assign shown_count  = shown_reg;
    assign in_manual    = (phase_reg == PH_MAN);

    // Configuration port. Registers are decoded by word address; the byte
    // offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_reg  <= GREEN_RST;
            yellow_reg <= YELLOW_RST;
            wait_reg   <= WAIT_RST;
            tick_reg   <= TICK_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_GREEN:  green_reg  <= pwdata[7:0];
                REG_YELLOW: yellow_reg <= pwdata[7:0];
                REG_WAIT:   wait_reg   <= pwdata[7:0];
                REG_TICK:   tick_reg   <= pwdata[4:0];
                default:    tick_reg   <= tick_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GREEN:  prdata = 32'(green_reg);
            REG_YELLOW: prdata = 32'(yellow_reg);
            REG_WAIT:   prdata = 32'(wait_reg);
            REG_TICK:   prdata = 32'(tick_reg);
            default:    prdata = 32'd0;
        endcase
    end

endmodule

[rtl/ttlc_checker.sv]
module ttlc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic       red_a,
    input logic       yellow_a,
    input logic       green_a,
    input logic       red_b,
    input logic       yellow_b,
    input logic       green_b,
    input logic [7:0] shown_count,
    input logic       in_manual
);

    // Both directions are never released at the same time.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !((green_a || yellow_a) && (green_b || yellow_b)))
        else $error("conflicting green or yellow lamps in both directions");

    // During the manual hold only the reds may be lit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && in_manual) |-> !(green_a || yellow_a || green_b || yellow_b))
        else $error("green or yellow lamp lit during manual hold");

    // During the manual hold both reds blink together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && in_manual) |-> (red_a == red_b))
        else $error("red lamps out of step during manual hold");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(shown_count)
            && $stable(in_manual) && $stable(red_a) && $stable(red_b)))
        else $error("stalled result word changed");

endmodule

bind two_way_traffic_light_controller ttlc_checker u_ttlc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .red_a        (red_a),
    .yellow_a     (yellow_a),
    .green_a      (green_a),
    .red_b        (red_b),
    .yellow_b     (yellow_b),
    .green_b      (green_b),
    .shown_count  (shown_count),
    .in_manual    (in_manual)
);

[tb/tb.sv]
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ttlc_pkg::*;

    // A stretch this long with no word moving on either channel and no
    // register access means the block has hung.
    localparam int HANG_LIMIT = 400;

    // One result word as the block presents it on the result channel.
    typedef struct packed {
        logic       red_a;
        logic       yellow_a;
        logic       green_a;
        logic       red_b;
        logic       yellow_b;
        logic       green_b;
        logic [7:0] shown_count;
        logic       in_manual;
    } lamp_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tick_valid = 1'b0;
    logic        tick_stall;
    logic        manual_button = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        red_a;
    logic        yellow_a;
    logic        green_a;
    logic        red_b;
    logic        yellow_b;
    logic        green_b;
    logic [7:0]  shown_count;
    logic        in_manual;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Lamp words that the controller must still produce, oldest first.
    lamp_word_t  expected_words[$];
    int          mismatch_count = 0;

    // When set, neither the tick sender nor the result receiver idles, so the
    // block runs at one word per cycle on both sides.
    bit          fast_mode = 1'b0;
    int          stall_left = 0;

    // Our own copy of the timing registers and of the controller state.
    logic [7:0]  cfg_green;
    logic [7:0]  cfg_yellow;
    logic [7:0]  cfg_wait;
    logic [4:0]  cfg_tick;
    logic [2:0]  ctl_phase;
    logic [7:0]  ctl_left;
    logic [7:0]  ctl_display;
    logic [4:0]  ctl_sub;
    logic [7:0]  ctl_hold;
    logic [5:0]  ctl_lamps;
    logic [7:0]  ctl_shown;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    two_way_traffic_light_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .manual_button (manual_button),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .red_a         (red_a),
        .yellow_a      (yellow_a),
        .green_a       (green_a),
        .red_b         (red_b),
        .yellow_b      (yellow_b),
        .green_b       (green_b),
        .shown_count   (shown_count),
        .in_manual     (in_manual),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // Controller prediction
    // ------------------------------------------------------------------

    // Puts the registers and the controller state back to their values
    // after reset: init phase, display primed at five, lamps dark.
    task automatic clear_controller();
        cfg_green   = GREEN_RST;
        cfg_yellow  = YELLOW_RST;
        cfg_wait    = WAIT_RST;
        cfg_tick    = TICK_RST;
        ctl_phase   = PH_INIT;
        ctl_left    = 8'd0;
        ctl_display = DISPLAY_RST;
        ctl_sub     = SUB_RST;
        ctl_hold    = 8'd0;
        ctl_lamps   = 6'd0;
        ctl_shown   = 8'd0;
    endtask

    // Advances the tick counter by one tick. A second is marked when the
    // counter is found at zero; it then reloads and still counts down, so a
    // zero reload wraps straight to 31.
    function automatic logic count_tick();
        logic second;
        second = 1'b0;
        if (ctl_sub == 5'd0)
        begin
            ctl_sub = cfg_tick;
            second = 1'b1;
        end
        ctl_sub = ctl_sub - 5'd1;
        return second;
    endfunction

    // Shared countdown of a running phase. The display shows its value from
    // before this tick. Returns high when the phase time has run out; a phase
    // that starts at zero and sees a second wraps to 255 instead.
    function automatic logic phase_expired();
        ctl_shown = ctl_display;
        if (count_tick())
        begin
            ctl_display = ctl_display - 8'd1;
            ctl_left    = ctl_left - 8'd1;
        end
        return ctl_left == 8'd0;
    endfunction

    // Runs one tick through the controller and queues the lamp word that the
    // block must return for it.
    task automatic advance_controller(input logic button);
        lamp_word_t word;
        case (ctl_phase)
            PH_INIT:
            begin
                ctl_left    = cfg_green;
                ctl_display = cfg_green + cfg_yellow;
                ctl_lamps   = LAMP_RA | LAMP_GB;
                ctl_shown   = ctl_display;
                ctl_phase   = PH_ONE;
            end
            PH_ONE:
            begin
                if (phase_expired())
                begin
                    ctl_lamps = (ctl_lamps & ~LAMP_B) | LAMP_YB;
                    ctl_left  = cfg_yellow;
                    ctl_phase = PH_TWO;
                end
                // The button wins even on the tick where the phase ends.
                if (button)
                begin
                    ctl_lamps = LAMP_RA | LAMP_RB;
                    ctl_hold  = cfg_wait;
                    ctl_phase = PH_MAN;
                end
            end
            PH_TWO:
            begin
                if (phase_expired())
                begin
                    ctl_left    = cfg_green;
                    ctl_lamps   = LAMP_GA | LAMP_RB;
                    ctl_display = cfg_green;
                    ctl_phase   = PH_THREE;
                end
            end
            PH_THREE:
            begin
                if (phase_expired())
                begin
                    ctl_left    = cfg_yellow;
                    ctl_lamps   = (ctl_lamps & ~LAMP_A) | LAMP_YA;
                    ctl_display = cfg_yellow;
                    ctl_phase   = PH_FOUR;
                end
            end
            PH_FOUR:
            begin
                if (phase_expired())
                begin
                    ctl_left    = cfg_green;
                    ctl_lamps   = LAMP_RA | LAMP_GB;
                    ctl_display = cfg_green + cfg_yellow;
                    ctl_phase   = PH_ONE;
                end
            end
            default:
            begin
            end
        endcase

        // The hold logic runs after the phase logic in the same tick, so the
        // tick that enters the hold already counts once more and shows the
        // hold time.
        if (ctl_phase == PH_MAN)
        begin
            ctl_shown = ctl_hold;
            if (count_tick())
            begin
                ctl_lamps = ctl_lamps ^ (LAMP_RA | LAMP_RB);
                ctl_hold  = ctl_hold - 8'd1;
            end
            if (ctl_hold == 8'd0)
                ctl_phase = PH_INIT;
        end

        word.red_a       = (ctl_lamps & LAMP_RA) != 6'd0;
        word.yellow_a    = (ctl_lamps & LAMP_YA) != 6'd0;
        word.green_a     = (ctl_lamps & LAMP_GA) != 6'd0;
        word.red_b       = (ctl_lamps & LAMP_RB) != 6'd0;
        word.yellow_b    = (ctl_lamps & LAMP_YB) != 6'd0;
        word.green_b     = (ctl_lamps & LAMP_GB) != 6'd0;
        word.shown_count = ctl_shown;
        word.in_manual   = ctl_phase == PH_MAN;
        expected_words.push_back(word);
    endtask

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Number of cycles a side waits before its next word.
    function automatic int draw_pause();
        return fast_mode ? 0 : $urandom_range(0, 10);
    endfunction

    // Sends one tick word. Valid stays high from one word to the next when no
    // pause is drawn, so it is never lowered and raised in the same step.
    task automatic send_tick(input logic button);
        int pause;
        pause = draw_pause();
        if (pause > 0)
        begin
            tick_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        tick_valid    <= 1'b1;
        manual_button <= button;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        advance_controller(button);
    endtask

    // Stops sending and waits until every queued lamp word has come back.
    // Each tick yields exactly one word, so nothing is left in flight then.
    task automatic settle();
        tick_valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // One APB write: a setup cycle, then the access cycle in which the
    // register takes the value.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (index)
            REG_GREEN:  cfg_green  = value[7:0];
            REG_YELLOW: cfg_yellow = value[7:0];
            REG_WAIT:   cfg_wait   = value[7:0];
            REG_TICK:   cfg_tick   = value[4:0];
            default:
            begin
            end
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_timing(input logic [7:0] green, input logic [7:0] yellow,
                                  input logic [7:0] hold, input logic [4:0] ticks);
        write_reg(REG_GREEN, {24'd0, green});
        write_reg(REG_YELLOW, {24'd0, yellow});
        write_reg(REG_WAIT, {24'd0, hold});
        write_reg(REG_TICK, {27'd0, ticks});
    endtask

    // The receiver holds off for a freshly drawn number of cycles after each
    // word it takes.
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
            stall_left = draw_pause();
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        result_stall <= (stall_left != 0);
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            if (mismatch_count < 10)
                $display("tb: %0t %s mismatch, expected %0d, got %0d", $realtime, name,
                         want, got);
            mismatch_count++;
        end
    endtask

    // Every word taken on the result channel is held against the oldest
    // prediction, one field at a time.
    task automatic check_word();
        lamp_word_t want;
        if (expected_words.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("tb: %0t result word with no tick waiting for it", $realtime);
            mismatch_count++;
            return;
        end
        want = expected_words.pop_front();
        compare_field("red_a", want.red_a, red_a);
        compare_field("yellow_a", want.yellow_a, yellow_a);
        compare_field("green_a", want.green_a, green_a);
        compare_field("red_b", want.red_b, red_b);
        compare_field("yellow_b", want.yellow_b, yellow_b);
        compare_field("green_b", want.green_b, green_b);
        compare_field("shown_count", want.shown_count, shown_count);
        compare_field("in_manual", want.in_manual, in_manual);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_word();
    end

    // Hang detection: the run ends when nothing has moved for too long.
    initial
    begin
        int silent_cycles;
        silent_cycles = 0;
        while (silent_cycles < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || psel || (tick_valid && !tick_stall)
                || (result_valid && !result_stall))
                silent_cycles = 0;
            else
                silent_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers at their reset values: the first tick leaves the init state
    // and the display starts from green plus yellow.
    task automatic test_power_up();
        repeat (4) send_tick(1'b0);
        settle();
    endtask

    // One-tick seconds and one-second phases are programmed; the tick counter still
    // runs down from its earlier reload, so these ticks stay in the first phase.
    task automatic test_full_cycle();
        program_timing(8'd1, 8'd1, 8'd2, 5'd1);
        repeat (8) send_tick(1'b0);
        settle();
    endtask

    // The button is held over several ticks: it is ignored outside the first
    // phase and starts the blinking hold inside it.
    task automatic test_manual_hold();
        repeat (4) send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        settle();
    endtask

    // Zero times wrap to 255 when a second is counted off them, a zero tick
    // reload wraps the tick counter to 31, and the top values make green plus
    // yellow overflow the display.
    task automatic test_edge_values();
        program_timing(8'd0, 8'd0, 8'd0, 5'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        settle();
        program_timing(8'd255, 8'd255, 8'd255, 5'd31);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        settle();
    endtask

    // Random traffic in chunks, each under its own timing. Most settings use
    // short times so that the phases, the hold and the restart come around
    // often; one uses the top values and one the zero times. Halfway through
    // each chunk the sender waits until every result word is back.
    task automatic test_random_traffic(input int total);
        int sent;
        int setting;
        int chunk;
        int press_odds;
        int i;
        sent    = 0;
        setting = 0;
        while (sent < total)
        begin
            if (setting == 2)
                program_timing(8'd255, 8'd255, 8'd255, 5'd31);
            else if (setting == 4)
                program_timing(8'd0, 8'd0, 8'd0, 5'd1);
            else
                program_timing(8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
                               8'($urandom_range(0, 4)), 5'($urandom_range(0, 3)));
            press_odds = $urandom_range(2, 24);
            chunk      = 60 + $urandom_range(0, 60);
            for (i = 0; i < chunk; i++)
            begin
                if (i % 40 == 0)
                    fast_mode = ($urandom_range(0, 2) == 0);
                if (i == chunk / 2)
                    settle();
                send_tick($urandom_range(1, press_odds) == 1);
            end
            settle();
            sent += chunk;
            setting++;
        end
        fast_mode = 1'b0;
    endtask

    initial
    begin
        clear_controller();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_full_cycle();
        test_manual_hold();
        test_edge_values();
        test_random_traffic(750);

        settle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
